@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent check forms, clocked on clock and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that must hold at every clock edge
`define ASSERT_HOLDS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/twtt_pkg.sv @@
// ----------------------------------------------------------------------------
// twtt_pkg
// widths, codes and controller/datapath link types of the timer table
// ----------------------------------------------------------------------------
`default_nettype none

package twtt_pkg;

   // payload and register widths
   localparam int OPCODE_W   = 2;
   localparam int ID_W       = 64;
   localparam int DELAY_W    = 16;
   localparam int WHEEL_W    = 11;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic [WHEEL_W-1:0] WHEEL_RESET = 11'd60;

   // item opcodes
   localparam logic [OPCODE_W-1:0] OP_TICK    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_ADD     = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_REFRESH = 2'd2;
   localparam logic [OPCODE_W-1:0] OP_CANCEL  = 2'd3;

   // result status codes
   localparam logic STATUS_FIRE   = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   // register index (word address)
   localparam logic [CSR_ADDR_W-3:0] REG_WHEEL_SIZE = 1'b0;

   // divider operand select
   localparam logic [1:0] DIV_SRC_TICK     = 2'd0;
   localparam logic [1:0] DIV_SRC_DELAY    = 2'd1;
   localparam logic [1:0] DIV_SRC_DEADLINE = 2'd2;

   // table read address select
   localparam logic [1:0] RD_SCAN  = 2'd0;
   localparam logic [1:0] RD_EMIT  = 2'd1;
   localparam logic [1:0] RD_MATCH = 2'd2;

   // controller to datapath
   typedef struct packed {
      logic       clear;
      logic       scan_run;
      logic       div_start;
      logic [1:0] div_src;
      logic       slot_load;
      logic       period_from_div;
      logic       period_from_mem;
      logic [1:0] rd_sel;
      logic       entry_write;
      logic       emit_skip;
      logic       emit_push;
      logic       reject_push;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [OPCODE_W-1:0] op;
      logic                scan_done;
      logic                match_found;
      logic                free_found;
      logic                div_done;
      logic                emit_end;
      logic                emit_hit;
      logic                out_free;
   } sts_type;

endpackage

`default_nettype wire

@@ rtl/twtt_req_if.sv @@
// ----------------------------------------------------------------------------
// twtt_req_if
// input item channel: valid/ready with opcode, timer id and delay
// ----------------------------------------------------------------------------
`default_nettype none

interface twtt_req_if import twtt_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OPCODE_W-1:0] opcode;
   logic [ID_W-1:0]     timer_id;
   logic [DELAY_W-1:0]  delay_ticks;

   modport source (output valid, output opcode, output timer_id, output delay_ticks,
                   input ready);
   modport sink   (input valid, input opcode, input timer_id, input delay_ticks,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/twtt_rsp_if.sv @@
// ----------------------------------------------------------------------------
// twtt_rsp_if
// result channel: valid/ready with fired id, status and last marker
// ----------------------------------------------------------------------------
`default_nettype none

interface twtt_rsp_if import twtt_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [ID_W-1:0] fired_id;
   logic            status;
   logic            last;

   modport source (output valid, output fired_id, output status, output last,
                   input ready);
   modport sink   (input valid, input fired_id, input status, input last,
                   output ready);
endinterface

`default_nettype wire

@@ rtl/twtt_div.sv @@
// ----------------------------------------------------------------------------
// twtt_div
// restoring remainder unit, one dividend bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module twtt_div import twtt_pkg::*; #(
   parameter int MAX_SLOTS = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [DELAY_W-1:0]            dividend,
   input  wire logic [$clog2(MAX_SLOTS):0]    divisor,
   output logic                               done,
   output logic [$clog2(MAX_SLOTS)-1:0]       rem
);

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int CNT_W  = $clog2(DELAY_W);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(DELAY_W - 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DELAY_W-1:0] dvd_ff;
   logic [SLOT_W:0]   dsr_ff;
   logic [SLOT_W-1:0] rem_ff;
   logic [SLOT_W:0]   trial;
   logic [SLOT_W:0]   diff;

   // shift in the next dividend bit and try the subtraction
   assign trial = {rem_ff, dvd_ff[DELAY_W-1]};
   assign diff  = trial - dsr_ff;

   // iteration control
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == LAST_CNT) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // partial remainder and operands
   always_ff @(posedge clock) begin
      if (start) begin
         dvd_ff <= dividend;
         dsr_ff <= divisor;
         rem_ff <= '0;
      end else if (busy_ff) begin
         dvd_ff <= dvd_ff << 1;
         if (trial >= dsr_ff) begin
            rem_ff <= diff[SLOT_W-1:0];
         end else begin
            rem_ff <= trial[SLOT_W-1:0];
         end
      end
   end

   assign done = done_ff;
   assign rem  = rem_ff;

   // checks
   `ASSERT_IMPL(a_div_no_restart, start, !busy_ff, "divider started while busy")
   `ASSERT_IMPL(a_div_done_idle, done_ff, !busy_ff, "divider done while still iterating")

endmodule

`default_nettype wire

@@ rtl/twtt_ctrl.sv @@
// ----------------------------------------------------------------------------
// twtt_ctrl
// sequencer: dispatch, table scan, remainder steps, entry write, emission
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module twtt_ctrl import twtt_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire sts_type sts,
   output cmd_type      cmd
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_DISPATCH  = 4'd1;
   localparam logic [3:0] ST_TICK_DIV  = 4'd2;
   localparam logic [3:0] ST_TICK_WAIT = 4'd3;
   localparam logic [3:0] ST_SCAN      = 4'd4;
   localparam logic [3:0] ST_EMIT_RD   = 4'd5;
   localparam logic [3:0] ST_EMIT_WR   = 4'd6;
   localparam logic [3:0] ST_REJECT    = 4'd7;
   localparam logic [3:0] ST_PER_DIV   = 4'd8;
   localparam logic [3:0] ST_PER_WAIT  = 4'd9;
   localparam logic [3:0] ST_PER_READ  = 4'd10;
   localparam logic [3:0] ST_PER_LOAD  = 4'd11;
   localparam logic [3:0] ST_DL_DIV    = 4'd12;
   localparam logic [3:0] ST_DL_WAIT   = 4'd13;
   localparam logic [3:0] ST_WRITE     = 4'd14;

   logic [3:0] state_ff, state_in;
   logic       div_wait_st;
   logic       out_load;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      cmd.rd_sel = RD_SCAN;
      req_ready  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.clear = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (sts.op == OP_TICK) begin
               state_in = ST_TICK_DIV;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_TICK_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_SRC_TICK;
            state_in      = ST_TICK_WAIT;
         end
         ST_TICK_WAIT: begin
            if (sts.div_done) begin
               cmd.slot_load = 1'b1;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.scan_done) begin
               case (sts.op)
                  OP_TICK: begin
                     state_in = ST_EMIT_RD;
                  end
                  OP_ADD: begin
                     if (sts.match_found || sts.free_found) begin
                        state_in = ST_PER_DIV;
                     end else begin
                        state_in = ST_REJECT;
                     end
                  end
                  OP_REFRESH: begin
                     state_in = sts.match_found ? ST_PER_READ : ST_IDLE;
                  end
                  default: begin
                     state_in = sts.match_found ? ST_WRITE : ST_IDLE;
                  end
               endcase
            end
         end
         ST_EMIT_RD: begin
            cmd.rd_sel = RD_EMIT;
            if (sts.emit_end) begin
               state_in = ST_IDLE;
            end else if (sts.emit_hit) begin
               state_in = ST_EMIT_WR;
            end else begin
               cmd.emit_skip = 1'b1;
            end
         end
         ST_EMIT_WR: begin
            cmd.rd_sel = RD_EMIT;
            if (sts.out_free) begin
               cmd.emit_push = 1'b1;
               state_in      = ST_EMIT_RD;
            end
         end
         ST_REJECT: begin
            if (sts.out_free) begin
               cmd.reject_push = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_PER_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_SRC_DELAY;
            state_in      = ST_PER_WAIT;
         end
         ST_PER_WAIT: begin
            if (sts.div_done) begin
               cmd.period_from_div = 1'b1;
               state_in            = ST_DL_DIV;
            end
         end
         ST_PER_READ: begin
            cmd.rd_sel = RD_MATCH;
            state_in   = ST_PER_LOAD;
         end
         ST_PER_LOAD: begin
            cmd.period_from_mem = 1'b1;
            state_in            = ST_DL_DIV;
         end
         ST_DL_DIV: begin
            cmd.div_start = 1'b1;
            cmd.div_src   = DIV_SRC_DEADLINE;
            state_in      = ST_DL_WAIT;
         end
         ST_DL_WAIT: begin
            if (sts.div_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            cmd.entry_write = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // states that wait on the remainder unit, and result loads
   assign div_wait_st = (state_ff == ST_TICK_WAIT) || (state_ff == ST_PER_WAIT) ||
                        (state_ff == ST_DL_WAIT);
   assign out_load    = cmd.emit_push || cmd.reject_push;

   // checks
   `ASSERT_IMPL(a_ctrl_div_wait, sts.div_done, div_wait_st, "remainder done outside a wait state")
   `ASSERT_IMPL(a_ctrl_push_free, out_load, sts.out_free, "result loaded over an untaken result")

endmodule

`default_nettype wire

@@ rtl/twtt_dp.sv @@
// ----------------------------------------------------------------------------
// twtt_dp
// timer table datapath: entry memories, scan pipeline, slot pointer,
// remainder unit and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module twtt_dp import twtt_pkg::*; #(
   parameter int MAX_TIMERS = 16,
   parameter int MAX_SLOTS  = 1024
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire cmd_type                    cmd,
   output sts_type                         sts,
   input  wire logic [$clog2(MAX_SLOTS):0] eff_size,
   input  wire logic [OPCODE_W-1:0]        req_opcode,
   input  wire logic [ID_W-1:0]            req_timer_id,
   input  wire logic [DELAY_W-1:0]         req_delay_ticks,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [ID_W-1:0]                 rsp_fired_id,
   output logic                            rsp_status,
   output logic                            rsp_last
);

   localparam int SLOT_W = $clog2(MAX_SLOTS);
   localparam int IDX_W  = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
   localparam int CNT_W  = $clog2(MAX_TIMERS + 1);
   localparam logic [CNT_W-1:0] CNT_END = CNT_W'(MAX_TIMERS);

   // captured item
   logic [OPCODE_W-1:0] op_ff;
   logic [ID_W-1:0]     id_ff;
   logic [DELAY_W-1:0]  delay_ff;

   // wheel and table state
   logic [SLOT_W-1:0]     cur_slot_ff;
   logic [MAX_TIMERS-1:0] live_ff;
   logic [ID_W-1:0]       key_mem      [MAX_TIMERS];
   logic [SLOT_W-1:0]     period_mem   [MAX_TIMERS];
   logic [SLOT_W-1:0]     deadline_mem [MAX_TIMERS];
   logic                  silenced_mem [MAX_TIMERS];

   // registered read port
   logic [IDX_W-1:0]  rd_addr;
   logic [ID_W-1:0]   rd_key_ff;
   logic [SLOT_W-1:0] rd_period_ff;
   logic [SLOT_W-1:0] rd_deadline_ff;
   logic              rd_silenced_ff;

   // scan and emission
   logic [CNT_W-1:0]      scan_addr_ff;
   logic                  eval_valid_ff;
   logic [IDX_W-1:0]      eval_idx_ff;
   logic                  match_found_ff;
   logic [IDX_W-1:0]      match_idx_ff;
   logic                  free_found_ff;
   logic [IDX_W-1:0]      free_idx_ff;
   logic [MAX_TIMERS-1:0] fire_mask_ff;
   logic [CNT_W-1:0]      emit_idx_ff;
   logic [IDX_W-1:0]      emit_sel;
   logic [MAX_TIMERS-1:0] emit_rest;
   logic                  scan_issue;
   logic                  eval_live;
   logic                  key_hit;
   logic                  expire;
   logic                  is_tick;

   // remainder unit
   logic [SLOT_W-1:0]  period_tmp_ff;
   logic [SLOT_W:0]    slot_inc;
   logic [SLOT_W:0]    slot_sum;
   logic [DELAY_W-1:0] div_dividend;
   logic               div_done;
   logic [SLOT_W-1:0]  div_rem;

   // entry write
   logic [IDX_W-1:0] wr_idx;
   logic             wr_add;
   logic             wr_refresh;
   logic             wr_cancel;

   // result register
   logic            out_valid_ff;
   logic [ID_W-1:0] out_id_ff;
   logic            out_status_ff;
   logic            out_last_ff;
   logic            out_free;

   // item capture
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         op_ff    <= req_opcode;
         id_ff    <= req_timer_id;
         delay_ff <= req_delay_ticks;
      end
   end

   assign is_tick = (op_ff == OP_TICK);

   // remainder operands
   assign slot_inc = {1'b0, cur_slot_ff} + (SLOT_W+1)'(1);
   assign slot_sum = {1'b0, cur_slot_ff} + {1'b0, period_tmp_ff};

   always_comb begin
      case (cmd.div_src)
         DIV_SRC_TICK:     div_dividend = DELAY_W'(slot_inc);
         DIV_SRC_DEADLINE: div_dividend = DELAY_W'(slot_sum);
         default:          div_dividend = delay_ff;
      endcase
   end

   twtt_div #(
      .MAX_SLOTS (MAX_SLOTS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_dividend),
      .divisor  (eff_size),
      .done     (div_done),
      .rem      (div_rem)
   );

   // slot pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_slot_ff <= '0;
      end else if (cmd.slot_load) begin
         cur_slot_ff <= div_rem;
      end
   end

   // period held between the two remainder steps
   always_ff @(posedge clock) begin
      if (cmd.period_from_div) begin
         period_tmp_ff <= div_rem;
      end else if (cmd.period_from_mem) begin
         period_tmp_ff <= rd_period_ff;
      end
   end

   // read address select
   assign emit_sel = emit_idx_ff[IDX_W-1:0];

   always_comb begin
      case (cmd.rd_sel)
         RD_EMIT:  rd_addr = emit_sel;
         RD_MATCH: rd_addr = match_idx_ff;
         default:  rd_addr = scan_addr_ff[IDX_W-1:0];
      endcase
   end

   // entry write decode
   assign wr_idx     = match_found_ff ? match_idx_ff : free_idx_ff;
   assign wr_add     = cmd.entry_write && (op_ff == OP_ADD);
   assign wr_refresh = cmd.entry_write && (op_ff == OP_REFRESH);
   assign wr_cancel  = cmd.entry_write && (op_ff == OP_CANCEL);

   // entry memories, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      rd_key_ff      <= key_mem[rd_addr];
      rd_period_ff   <= period_mem[rd_addr];
      rd_deadline_ff <= deadline_mem[rd_addr];
      rd_silenced_ff <= silenced_mem[rd_addr];
      if (wr_add) begin
         key_mem[wr_idx]    <= id_ff;
         period_mem[wr_idx] <= period_tmp_ff;
      end
      if (wr_add || wr_refresh) begin
         deadline_mem[wr_idx] <= div_rem;
      end
      if (wr_add || wr_cancel) begin
         silenced_mem[wr_idx] <= wr_cancel;
      end
   end

   // evaluation of the entry read in the previous cycle
   assign scan_issue = cmd.scan_run && (scan_addr_ff < CNT_END);
   assign eval_live  = live_ff[eval_idx_ff];
   assign key_hit    = eval_live && (rd_key_ff == id_ff);
   assign expire     = eval_live && (rd_deadline_ff == cur_slot_ff);
   assign emit_rest  = fire_mask_ff & ~(MAX_TIMERS'(1) << emit_sel);

   // scan pipeline, live bits and fire mask
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff   <= '0;
         eval_valid_ff  <= 1'b0;
         eval_idx_ff    <= '0;
         match_found_ff <= 1'b0;
         match_idx_ff   <= '0;
         free_found_ff  <= 1'b0;
         free_idx_ff    <= '0;
         fire_mask_ff   <= '0;
         emit_idx_ff    <= '0;
         live_ff        <= '0;
      end else if (cmd.clear) begin
         scan_addr_ff   <= '0;
         eval_valid_ff  <= 1'b0;
         match_found_ff <= 1'b0;
         free_found_ff  <= 1'b0;
         fire_mask_ff   <= '0;
         emit_idx_ff    <= '0;
      end else begin
         eval_valid_ff <= scan_issue;
         if (scan_issue) begin
            scan_addr_ff <= scan_addr_ff + CNT_W'(1);
            eval_idx_ff  <= scan_addr_ff[IDX_W-1:0];
         end
         // tick: free expiring entries and note those that fire
         if (eval_valid_ff && is_tick && expire) begin
            live_ff[eval_idx_ff]      <= 1'b0;
            fire_mask_ff[eval_idx_ff] <= !rd_silenced_ff;
         end
         // id lookup: first live match and first free entry
         if (eval_valid_ff && !is_tick) begin
            if (key_hit && !match_found_ff) begin
               match_found_ff <= 1'b1;
               match_idx_ff   <= eval_idx_ff;
            end
            if (!eval_live && !free_found_ff) begin
               free_found_ff <= 1'b1;
               free_idx_ff   <= eval_idx_ff;
            end
         end
         // emission walk
         if (cmd.emit_skip) begin
            emit_idx_ff <= emit_idx_ff + CNT_W'(1);
         end
         if (cmd.emit_push) begin
            fire_mask_ff[emit_sel] <= 1'b0;
            emit_idx_ff            <= emit_idx_ff + CNT_W'(1);
         end
         if (wr_add) begin
            live_ff[wr_idx] <= 1'b1;
         end
      end
   end

   // result register
   assign out_free = !out_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit_push || cmd.reject_push) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit_push) begin
         out_id_ff     <= rd_key_ff;
         out_status_ff <= STATUS_FIRE;
         out_last_ff   <= (emit_rest == '0);
      end else if (cmd.reject_push) begin
         out_id_ff     <= id_ff;
         out_status_ff <= STATUS_REJECT;
         out_last_ff   <= 1'b1;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_fired_id = out_id_ff;
   assign rsp_status   = out_status_ff;
   assign rsp_last     = out_last_ff;

   // status to the controller
   always_comb begin
      sts             = '0;
      sts.op          = op_ff;
      sts.scan_done   = (scan_addr_ff == CNT_END) && !eval_valid_ff;
      sts.match_found = match_found_ff;
      sts.free_found  = free_found_ff;
      sts.div_done    = div_done;
      sts.emit_end    = (emit_idx_ff == CNT_END);
      sts.emit_hit    = fire_mask_ff[emit_sel];
      sts.out_free    = out_free;
   end

   // checks
   `ASSERT_IMPL(a_dp_mask_tick, fire_mask_ff != '0, is_tick, "fire mask set outside a tick")
   `ASSERT_IMPL(a_dp_add_target, wr_add, match_found_ff || free_found_ff, "add written with no target entry")

endmodule

`default_nettype wire

@@ rtl/timing_wheel_timer_table.sv @@
// ----------------------------------------------------------------------------
// timing_wheel_timer_table
// hashed timing wheel timer table with add, refresh, cancel and tick items
// ----------------------------------------------------------------------------
//   channel   dir   protocol     payload
//   req_bus   in    valid/ready  opcode, timer_id, delay_ticks
//   rsp_bus   out   valid/ready  fired_id, status, last
//   csr_*     in    apb write    wheel_size at byte address 0
//
// one item at a time; each is accepted, then dispatched. add: table scan, two
// remainder passes in the shared divider, write. refresh: scan, read of the
// stored period, one remainder pass, write. cancel: scan, write. a rejected add
// pushes a reject result after the scan; refresh or cancel of a missing id ends
// after the scan. tick: one remainder pass, scan, then one result per fired timer.
// the table scan reads one entry per cycle over the read port; the remainder unit
// is bit-serial. reset is synchronous; no clearing pass, the next item is taken
// at once. a stalled result holds in the output register; emission waits for it.
// ----------------------------------------------------------------------------
`default_nettype none

module timing_wheel_timer_table import twtt_pkg::*; #(
   parameter int MAX_TIMERS = 16,
   parameter int MAX_SLOTS  = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   twtt_req_if.sink                   req_bus,
   twtt_rsp_if.source                 rsp_bus,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   localparam int SLOT_W = $clog2(MAX_SLOTS);

   logic [WHEEL_W-1:0] wheel_size_ff;
   logic [SLOT_W:0]    eff_size;
   logic               csr_hit;
   cmd_type            cmd;
   sts_type            sts;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == REG_WHEEL_SIZE);

   always_ff @(posedge clock) begin
      if (reset) begin
         wheel_size_ff <= WHEEL_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_hit) begin
         wheel_size_ff <= csr_pwdata[WHEEL_W-1:0];
      end
   end

   assign csr_prdata = csr_hit ? CSR_DATA_W'(wheel_size_ff) : '0;

   // wheel size clamped to one .. MAX_SLOTS
   always_comb begin
      if (wheel_size_ff == '0) begin
         eff_size = (SLOT_W+1)'(1);
      end else if (32'(wheel_size_ff) > 32'(MAX_SLOTS)) begin
         eff_size = (SLOT_W+1)'(MAX_SLOTS);
      end else begin
         eff_size = (SLOT_W+1)'(wheel_size_ff);
      end
   end

   // sequencer
   twtt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table datapath
   twtt_dp #(
      .MAX_TIMERS (MAX_TIMERS),
      .MAX_SLOTS  (MAX_SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .eff_size        (eff_size),
      .req_opcode      (req_bus.opcode),
      .req_timer_id    (req_bus.timer_id),
      .req_delay_ticks (req_bus.delay_ticks),
      .rsp_valid       (rsp_bus.valid),
      .rsp_ready       (rsp_bus.ready),
      .rsp_fired_id    (rsp_bus.fired_id),
      .rsp_status      (rsp_bus.status),
      .rsp_last        (rsp_bus.last)
   );

endmodule

`default_nettype wire
